// ----- hw/rtl/kfq_pkg.sv -----
// Shared constants and codes for the keyed FIFO queue.
package kfq_pkg;

    localparam int OP_W  = 2;
    localparam int KEY_W = 16;
    localparam int VAL_W = 32;
    localparam int POS_W = 5;
    localparam int ST_W  = 2;
    localparam int CNT_W = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_DUP    = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_ABSENT = 2'd3;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [VAL_W-1:0] t_val;

endpackage

// ----- hw/rtl/kfq_if.sv -----
// Request and response channel interfaces of the keyed FIFO queue.
interface kfq_req_if;
    logic                      valid;
    logic                      ready;
    logic [kfq_pkg::OP_W-1:0]  op;
    kfq_pkg::t_key             key;
    kfq_pkg::t_val             value;
    logic [kfq_pkg::POS_W-1:0] position;

    modport source (output valid, output op, output key, output value, output position,
                    input ready);
    modport sink   (input valid, input op, input key, input value, input position,
                    output ready);
endinterface

interface kfq_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [kfq_pkg::ST_W-1:0]  status;
    kfq_pkg::t_key             out_key;
    kfq_pkg::t_val             out_value;
    logic [kfq_pkg::CNT_W-1:0] count;

    modport source (output valid, output status, output out_key, output out_value,
                    output count, input ready);
    modport sink   (input valid, input status, input out_key, input out_value,
                    input count, output ready);
endinterface

// ----- hw/rtl/keyed_fifo_queue.sv -----
// Keyed FIFO queue: bounded FIFO of key/value entries with unique keys.
//
//  channel  | dir | payload                              | role
//  ---------+-----+--------------------------------------+------------------------------
//  i_req    | in  | op, key, value, position             | insert / pop / read request
//  o_rsp    | out | status, out_key, out_value, count    | one result item per request
//
// Steps: pop, read and the unused opcode pass through accept, execute and finish.
//   Insert stays in execute while the duplicate check reads every stored key
//   through the single memory read port, one key per cycle, and stops early
//   on a match.
// Reset: synchronous, active low; clears head, count, sequencer and output valid.
//   Entry memories are not cleared; only occupied slots are ever read.
// Stalls: a finished result sits in the output register; the next item is
//   accepted meanwhile, and its own finish waits until that register is free.
module keyed_fifo_queue #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kfq_req_if.sink     i_req,
    kfq_rsp_if.source   o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // slot index
    localparam int CW = $clog2(DEPTH + 1);                   // entry count
    localparam int SW = CW + 1;                              // slot sum
    localparam int MW = (CW > kfq_pkg::POS_W) ? CW : kfq_pkg::POS_W;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // ring wrap: offset behind head -> slot (sum stays below 2*DEPTH)
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // entry memories
    kfq_pkg::t_key r_key_mem [DEPTH];
    kfq_pkg::t_val r_val_mem [DEPTH];
    kfq_pkg::t_key r_rd_key;
    kfq_pkg::t_val r_rd_val;

    // control state
    logic [1:0]                r_state, n_state;
    logic [AW-1:0]             r_head,  n_head;
    logic [CW-1:0]             r_cnt,   n_cnt;
    logic [CW-1:0]             r_idx,   n_idx;     // next scan offset to read
    logic                      r_pend,  n_pend;    // scan read in flight
    logic [kfq_pkg::ST_W-1:0]  r_st,    n_st;

    // captured request
    logic [kfq_pkg::OP_W-1:0]  r_op;
    kfq_pkg::t_key             r_key;
    kfq_pkg::t_val             r_val;
    logic [kfq_pkg::POS_W-1:0] r_pos;

    // output register
    logic                      r_out_valid, n_out_valid;
    logic [kfq_pkg::ST_W-1:0]  r_out_status, n_out_status;
    kfq_pkg::t_key             r_out_key, n_out_key;
    kfq_pkg::t_val             r_out_val, n_out_val;
    logic [kfq_pkg::CNT_W-1:0] r_out_cnt, n_out_cnt;

    // memory port controls
    logic          w_re;
    logic          w_we;
    logic [CW-1:0] w_rd_off;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;

    logic          w_accept;
    logic          w_out_free;
    logic          w_hit;
    logic          w_full;
    logic [MW-1:0] w_p;
    logic [MW-1:0] w_cnt_ext;

    // port copies seen by the bound checker
    logic                      w_req_valid, w_req_ready, w_rsp_valid, w_rsp_ready;
    logic [kfq_pkg::OP_W-1:0]  w_req_op;
    logic [kfq_pkg::ST_W-1:0]  w_rsp_status;
    logic [kfq_pkg::CNT_W-1:0] w_rsp_count;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    assign w_hit  = r_pend && (r_rd_key == r_key);
    assign w_full = (r_cnt == CW'(DEPTH));
    assign w_p    = (r_pos == '0) ? MW'(1) : MW'(r_pos);

    assign w_rd_addr = slot_of(r_head, w_rd_off);
    assign w_wr_addr = slot_of(r_head, r_cnt);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_pend       = 1'b0;
        n_st         = r_st;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_key    = r_out_key;
        n_out_val    = r_out_val;
        n_out_cnt    = r_out_cnt;
        w_re         = 1'b0;
        w_we         = 1'b0;
        w_rd_off     = '0;
        w_cnt_ext    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                    n_idx   = '0;
                    n_st    = kfq_pkg::ST_OK;
                end
            end

            S_EXEC: begin
                unique case (r_op)
                    kfq_pkg::OP_INSERT: begin
                        // scan every stored key; compare is in the cycle after the read
                        if (w_hit) begin
                            n_st    = kfq_pkg::ST_DUP;
                            n_state = S_DONE;
                        end else if (r_idx == r_cnt) begin
                            n_st    = w_full ? kfq_pkg::ST_FULL : kfq_pkg::ST_OK;
                            n_state = S_DONE;
                        end else begin
                            w_re     = 1'b1;
                            w_rd_off = r_idx;
                            n_idx    = r_idx + CW'(1);
                            n_pend   = 1'b1;
                        end
                    end
                    kfq_pkg::OP_POP: begin
                        n_state = S_DONE;
                        if (r_cnt == '0) begin
                            n_st = kfq_pkg::ST_ABSENT;
                        end else begin
                            w_re = 1'b1;
                        end
                    end
                    kfq_pkg::OP_READ: begin
                        n_state = S_DONE;
                        if (w_p > MW'(r_cnt)) begin
                            n_st = kfq_pkg::ST_ABSENT;
                        end else begin
                            w_re     = 1'b1;
                            w_rd_off = CW'(w_p - MW'(1));
                        end
                    end
                    kfq_pkg::OP_NOP: begin
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_DONE: begin
                if (w_out_free) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_status = r_st;
                    n_out_key    = '0;
                    n_out_val    = '0;
                    if (r_st == kfq_pkg::ST_OK) begin
                        if (r_op == kfq_pkg::OP_INSERT) begin
                            w_we  = 1'b1;
                            n_cnt = r_cnt + CW'(1);
                        end else if (r_op == kfq_pkg::OP_POP) begin
                            n_head    = slot_of(r_head, CW'(1));
                            n_cnt     = r_cnt - CW'(1);
                            n_out_key = r_rd_key;
                            n_out_val = r_rd_val;
                        end else if (r_op == kfq_pkg::OP_READ) begin
                            n_out_key = r_rd_key;
                            n_out_val = r_rd_val;
                        end
                    end
                    w_cnt_ext = MW'(n_cnt);
                    n_out_cnt = w_cnt_ext[kfq_pkg::CNT_W-1:0];   // low bits only
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_key_mem[w_wr_addr] <= r_key;
            r_val_mem[w_wr_addr] <= r_val;
        end
        if (w_re) begin
            r_rd_key <= r_key_mem[w_rd_addr];
            r_rd_val <= r_val_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_st        <= kfq_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_req.op;
            r_key <= i_req.key;
            r_val <= i_req.value;
            r_pos <= i_req.position;
        end
        r_out_status <= n_out_status;
        r_out_key    <= n_out_key;
        r_out_val    <= n_out_val;
        r_out_cnt    <= n_out_cnt;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.out_key   = r_out_key;
    assign o_rsp.out_value = r_out_val;
    assign o_rsp.count     = r_out_cnt;

    assign w_req_valid  = i_req.valid;
    assign w_req_ready  = i_req.ready;
    assign w_req_op     = i_req.op;
    assign w_rsp_valid  = o_rsp.valid;
    assign w_rsp_ready  = o_rsp.ready;
    assign w_rsp_status = o_rsp.status;
    assign w_rsp_count  = o_rsp.count;

endmodule

// ----- hw/rtl/kfq_chk.sv -----
// Port-level checker for the keyed FIFO queue, bound to the top level.
module kfq_chk #(
    parameter int DEPTH = 16
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_req_valid,
    input logic                      i_req_ready,
    input logic [kfq_pkg::OP_W-1:0]  i_req_op,
    input logic                      i_rsp_valid,
    input logic                      i_rsp_ready,
    input logic [kfq_pkg::ST_W-1:0]  i_rsp_status,
    input logic [kfq_pkg::CNT_W-1:0] i_rsp_count
);

    localparam logic [kfq_pkg::CNT_W-1:0] DEPTH_LOW = kfq_pkg::CNT_W'(DEPTH);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
                                        && $stable(i_rsp_count))
        else $error("kfq: stalled result changed");

    // full is only reported with the queue at capacity
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == kfq_pkg::ST_FULL) |-> i_rsp_count == DEPTH_LOW)
        else $error("kfq: full status below capacity");

    // a duplicate needs a stored entry
    a_dup_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == kfq_pkg::ST_DUP) |-> i_rsp_count != '0)
        else $error("kfq: duplicate reported on empty queue");

    // count never exceeds capacity; checked only while DEPTH fits the count field
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (DEPTH > 31) || (i_rsp_count <= DEPTH_LOW))
        else $error("kfq: count above capacity");

    // an accepted pop is followed by a busy cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_op == kfq_pkg::OP_POP) |=> !i_req_ready)
        else $error("kfq: request taken while busy");

endmodule

bind keyed_fifo_queue kfq_chk #(.DEPTH(DEPTH)) u_kfq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (w_req_valid),
    .i_req_ready  (w_req_ready),
    .i_req_op     (w_req_op),
    .i_rsp_valid  (w_rsp_valid),
    .i_rsp_ready  (w_rsp_ready),
    .i_rsp_status (w_rsp_status),
    .i_rsp_count  (w_rsp_count)
);

// ----- dv/tb_keyed_fifo_queue.sv -----
// Testbench for keyed_fifo_queue: directed cases and random insert/pop/read traffic checked by a predictor.
`timescale 1ns / 1ps

module tb_keyed_fifo_queue;

    // Queue depth of the instance under test; the predictor mirrors it.
    localparam int QDEPTH = 16;
    // Cycles without any accepted item before the run is declared hung.
    // The worst honest gap is an insert walking a full queue behind the receiver
    // hold-off, so this leaves a wide margin.
    localparam int STALL_LIMIT = 5000;
    // Settle time after the last expected result.
    localparam int TAIL_CYCLES = 40;
    localparam int POOL_SIZE   = 24;

    // One result item as the block should present it.
    typedef struct {
        logic [kfq_pkg::ST_W-1:0]  status;
        kfq_pkg::t_key             key;
        kfq_pkg::t_val             value;
        logic [kfq_pkg::CNT_W-1:0] count;
    } t_queue_result;

    // Shadow of the keyed queue plus the list of results still owed by the block.
    class queue_scoreboard;
        kfq_pkg::t_key key_mem [QDEPTH];
        kfq_pkg::t_val val_mem [QDEPTH];
        int unsigned   head;
        int unsigned   held;
        int unsigned   peak_held;
        t_queue_result owed_results[$];
        int unsigned   errors;
        int unsigned   checked;
        int unsigned   op_seen[4];
        int unsigned   status_seen[4];

        function new();
            head      = 0;
            held      = 0;
            peak_held = 0;
            errors    = 0;
            checked   = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        // Update the shadow queue for one accepted request and queue its result.
        function void note_request(logic [kfq_pkg::OP_W-1:0] op, kfq_pkg::t_key k,
                                   kfq_pkg::t_val v, logic [kfq_pkg::POS_W-1:0] pos);
            t_queue_result exp_r;
            int unsigned   i;
            int unsigned   p;
            int unsigned   slot;
            bit            dup;
            exp_r.status = kfq_pkg::ST_OK;
            exp_r.key    = '0;
            exp_r.value  = '0;
            op_seen[op]++;
            case (op)
                kfq_pkg::OP_INSERT: begin
                    // duplicate check covers every held entry, tail included
                    dup = 1'b0;
                    for (i = 0; i < held; i++) begin
                        if (key_mem[(head + i) % QDEPTH] == k) dup = 1'b1;
                    end
                    if (dup) begin
                        exp_r.status = kfq_pkg::ST_DUP;
                    end else if (held >= QDEPTH) begin
                        exp_r.status = kfq_pkg::ST_FULL;
                    end else begin
                        slot          = (head + held) % QDEPTH;
                        key_mem[slot] = k;
                        val_mem[slot] = v;
                        held++;
                        if (held > peak_held) peak_held = held;
                    end
                end
                kfq_pkg::OP_POP: begin
                    if (held == 0) begin
                        exp_r.status = kfq_pkg::ST_ABSENT;
                    end else begin
                        exp_r.key   = key_mem[head];
                        exp_r.value = val_mem[head];
                        head        = (head + 1) % QDEPTH;
                        held--;
                    end
                end
                kfq_pkg::OP_READ: begin
                    p = (pos == 0) ? 1 : pos;
                    if (p > held) begin
                        exp_r.status = kfq_pkg::ST_ABSENT;
                    end else begin
                        slot        = (head + p - 1) % QDEPTH;
                        exp_r.key   = key_mem[slot];
                        exp_r.value = val_mem[slot];
                    end
                end
                default: ; // unused opcode: no change, status ok
            endcase
            exp_r.count = kfq_pkg::CNT_W'(held);
            status_seen[exp_r.status]++;
            owed_results.push_back(exp_r);
        endfunction

        task report(string what);
            errors++;
            // keep the log readable if the block is badly broken
            if (errors <= 50) $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        // Compare one accepted result against the oldest owed result.
        task check_result(logic [kfq_pkg::ST_W-1:0] st, kfq_pkg::t_key k,
                          kfq_pkg::t_val v, logic [kfq_pkg::CNT_W-1:0] cnt);
            t_queue_result exp_r;
            if (owed_results.size() == 0) begin
                report($sformatf("unexpected result st=%0d key=%h val=%h cnt=%0d",
                                 st, k, v, cnt));
            end else begin
                exp_r = owed_results.pop_front();
                checked++;
                if (st !== exp_r.status)
                    report($sformatf("result %0d status %0d, want %0d",
                                     checked, st, exp_r.status));
                if (k !== exp_r.key)
                    report($sformatf("result %0d out_key %h, want %h",
                                     checked, k, exp_r.key));
                if (v !== exp_r.value)
                    report($sformatf("result %0d out_value %h, want %h",
                                     checked, v, exp_r.value));
                if (cnt !== exp_r.count)
                    report($sformatf("result %0d count %0d, want %0d",
                                     checked, cnt, exp_r.count));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    kfq_req_if req_ch ();
    kfq_rsp_if rsp_ch ();

    keyed_fifo_queue #(
        .DEPTH (QDEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    queue_scoreboard sb;

    // Idle rates in percent of cycles; changed between phases by the main thread.
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    // Receiver hold-off request, picked up by the receiver process.
    int            rx_hold_req = 0;
    kfq_pkg::t_key key_pool [POOL_SIZE];
    int            stall_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, plus a long hold-off requested by the main thread
    // that it counts down itself so the block fills and stalls its input.
    initial begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Monitor: both channels are sampled at the edge, before the edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.op, req_ch.key, req_ch.value, req_ch.position);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.status, rsp_ch.out_key, rsp_ch.out_value,
                                rsp_ch.count);
        end
    end

    // Watchdog: any accepted item on either side resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready)
                || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item accepted for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one request and hold it until the block takes it. The random idle
    // gap goes in front, so valid drops only when a gap is actually taken.
    task automatic send_request(logic [kfq_pkg::OP_W-1:0] op, kfq_pkg::t_key k,
                                kfq_pkg::t_val v, logic [kfq_pkg::POS_W-1:0] pos);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.key      <= k;
        req_ch.value    <= v;
        req_ch.position <= pos;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Mixed traffic. The insert share swings every 40 items so the queue keeps
    // travelling between empty and full; keys come mostly from a small pool so
    // duplicates are common, and most read positions lie at most two past the fill level.
    task automatic run_mix(int n_items);
        int unsigned               ins_pct;
        int unsigned               r;
        int unsigned               top;
        logic [kfq_pkg::OP_W-1:0]  op;
        kfq_pkg::t_key             k;
        logic [kfq_pkg::POS_W-1:0] pos;
        ins_pct = 50;
        foreach (key_pool[i]) key_pool[i] = kfq_pkg::t_key'($urandom);
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 0) ins_pct = $urandom_range(25, 80);
            if ($urandom_range(99) < ins_pct) begin
                op = kfq_pkg::OP_INSERT;
            end else begin
                r  = $urandom_range(99);
                op = (r < 45) ? kfq_pkg::OP_POP
                   : (r < 93) ? kfq_pkg::OP_READ : kfq_pkg::OP_NOP;
            end
            k = ($urandom_range(99) < 70) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                          : kfq_pkg::t_key'($urandom);
            if ($urandom_range(99) < 80) begin
                top = (sb.held + 2 > 31) ? 31 : sb.held + 2;
                pos = kfq_pkg::POS_W'($urandom_range(top));
            end else begin
                pos = kfq_pkg::POS_W'($urandom_range(31));
            end
            send_request(op, k, kfq_pkg::t_val'($urandom), pos);
        end
    endtask

    initial begin
        sb = new();
        req_ch.valid    <= 1'b0;
        req_ch.op       <= kfq_pkg::OP_NOP;
        req_ch.key      <= '0;
        req_ch.value    <= '0;
        req_ch.position <= '0;
        i_rst_n         <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: empty-queue cases, field extremes, duplicates, full queue
        // pop and read of an empty queue, then the unused opcode
        send_request(kfq_pkg::OP_POP,    16'h0000, 32'h0000_0000, 5'd0);
        send_request(kfq_pkg::OP_READ,   16'h0000, 32'h0000_0000, 5'd0);
        send_request(kfq_pkg::OP_NOP,    16'hFFFF, 32'hFFFF_FFFF, 5'd31);
        send_request(kfq_pkg::OP_INSERT, 16'h0000, 32'h0000_0000, 5'd0);
        send_request(kfq_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
        // duplicates of the head and of the tail
        send_request(kfq_pkg::OP_INSERT, 16'h0000, 32'hA5A5_5A5A, 5'd0);
        send_request(kfq_pkg::OP_INSERT, 16'hFFFF, 32'h1234_5678, 5'd0);
        send_request(kfq_pkg::OP_READ,   16'h0000, 32'h0000_0000, 5'd1);
        send_request(kfq_pkg::OP_READ,   16'h0000, 32'h0000_0000, 5'd2);
        // one past the tail
        send_request(kfq_pkg::OP_READ,   16'h0000, 32'h0000_0000, 5'd3);
        for (int i = 0; i < QDEPTH - 2; i++)
            send_request(kfq_pkg::OP_INSERT, 16'h0100 + 16'(i),
                         kfq_pkg::t_val'($urandom), 5'd0);
        // full queue, then full and duplicate
        send_request(kfq_pkg::OP_INSERT, 16'h7777, 32'h0BAD_F00D, 5'd0);
        send_request(kfq_pkg::OP_INSERT, 16'hFFFF, 32'h0BAD_F00D, 5'd0);
        // last slot
        send_request(kfq_pkg::OP_READ,   16'h0000, 32'h0000_0000, 5'd16);
        send_request(kfq_pkg::OP_POP,    16'h0000, 32'h0000_0000, 5'd0);

        // --- random, sender idles little and receiver a lot
        tx_idle_pct = 11;
        rx_idle_pct = 66;
        run_mix(330);

        // --- random, the other way round
        tx_idle_pct = 66;
        rx_idle_pct = 11;
        run_mix(330);

        // --- back-pressure: receiver holds off while inserts keep coming
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 400;
        for (int i = 0; i < 30; i++)
            send_request(kfq_pkg::OP_INSERT, kfq_pkg::t_key'($urandom),
                         kfq_pkg::t_val'($urandom), 5'd0);

        // --- random with no idling on either side
        run_mix(330);

        @(posedge i_clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d results: %0d inserts, %0d pops, %0d reads, %0d unused ops",
                 sb.checked, sb.op_seen[kfq_pkg::OP_INSERT], sb.op_seen[kfq_pkg::OP_POP],
                 sb.op_seen[kfq_pkg::OP_READ], sb.op_seen[kfq_pkg::OP_NOP]);
        $display("status ok/dup/full/absent = %0d/%0d/%0d/%0d, deepest fill %0d, %0d bad",
                 sb.status_seen[kfq_pkg::ST_OK], sb.status_seen[kfq_pkg::ST_DUP],
                 sb.status_seen[kfq_pkg::ST_FULL], sb.status_seen[kfq_pkg::ST_ABSENT],
                 sb.peak_held, sb.errors);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/kfq_pkg.sv
hw/rtl/kfq_if.sv
hw/rtl/keyed_fifo_queue.sv
hw/rtl/kfq_chk.sv
dv/tb_keyed_fifo_queue.sv
